### hdl/pva_pkg.sv
// Shared types and constants for the priority voice allocator.
// Entry layout of the voice memory, memory request, selector status, FSM states.
// No dependencies.
package pva_pkg;

  localparam int VoiceW  = 5;
  localparam int PrioW   = 8;
  localparam int AgeW    = 16;
  localparam int EnvW    = 16;
  localparam int StatusW = 3;

  localparam logic [EnvW-1:0] ENV_MAX = 16'hffff;

  typedef enum logic [1:0] {
    KIND_KEY_ON     = 2'd0,
    KIND_ENV_UPDATE = 2'd1,
    KIND_QUERY      = 2'd2,
    KIND_DIRECT_ON  = 2'd3
  } kind_e;

  localparam logic [StatusW-1:0] STATUS_OFF          = 3'd0;
  localparam logic [StatusW-1:0] STATUS_KEYED_SOUND  = 3'd1;
  localparam logic [StatusW-1:0] STATUS_REL_SOUND    = 3'd2;
  localparam logic [StatusW-1:0] STATUS_KEYED_SILENT = 3'd3;
  localparam logic [StatusW-1:0] STATUS_BAD_VOICE    = 3'd4;

  // age holds the voice age minus the global epoch
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [AgeW-1:0]  age;
    logic             keyed;
    logic             is_off;
    logic [EnvW-1:0]  env;
  } voice_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [VoiceW-1:0] addr;
    voice_entry_t      wdata;
  } mem_req_t;

  typedef struct packed {
    logic              found;
    logic              is_free;
    logic [VoiceW-1:0] idx;
  } sel_t;

  typedef struct packed {
    logic               accepted;
    logic [VoiceW-1:0]  chosen_voice;
    logic               was_free;
    logic [StatusW-1:0] status_code;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_START,
    S_RD,
    S_WR,
    S_DONE
  } state_e;

endpackage

### hdl/pva_if.sv
// Valid/ready channel interfaces for the voice allocator request and result.
// Depends on pva_pkg for field widths.
interface pva_in_if import pva_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [VoiceW-1:0]   voice;
  logic [PrioW-1:0]    tone_priority;
  logic                tone_valid;
  logic                sample_valid;
  logic                phase_off;
  logic [EnvW-1:0]     envelope_level;

  modport source (
    output valid, kind, voice, tone_priority, tone_valid, sample_valid, phase_off,
           envelope_level,
    input  ready
  );
  modport sink (
    input  valid, kind, voice, tone_priority, tone_valid, sample_valid, phase_off,
           envelope_level,
    output ready
  );
endinterface

interface pva_out_if import pva_pkg::*;;
  logic                valid;
  logic                ready;
  logic                accepted;
  logic [VoiceW-1:0]   chosen_voice;
  logic                was_free;
  logic [StatusW-1:0]  status_code;

  modport source (
    output valid, accepted, chosen_voice, was_free, status_code,
    input  ready
  );
  modport sink (
    input  valid, accepted, chosen_voice, was_free, status_code,
    output ready
  );
endinterface

### hdl/priority_voice_allocator_unit.sv
// Priority voice allocator top level: control FSM, age epoch, result register.
// Depends on pva_pkg, pva_if, pva_voice_mem and pva_select.
//
//   channel   dir  handshake     payload
//   item_i    in   valid/ready   kind, voice, tone_priority, tone_valid,
//                                sample_valid, phase_off, envelope_level
//   result_o  out  valid/ready   accepted, chosen_voice, was_free, status_code
//
// Key-on: a scan of the voice memory at one entry per cycle; it ends early at the
// first free voice.
// Envelope update and status query: read, modify, write back.
// Direct key-on: S_START, S_DONE. Invalid tone, or bad voice on update or query: S_DONE.
// Reset: all voices read as off at once through per-entry valid bits.
// A new item is taken while the previous result waits in the output register;
// a second finished result holds the FSM until result_o transfers.
module priority_voice_allocator_unit import pva_pkg::*; #(
  parameter int VOICE_COUNT = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pva_in_if.sink    item_i,
  pva_out_if.source result_o
);

  localparam int AW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int CW  = AW + 1;
  localparam int VW1 = VoiceW + 1;

  state_e             state_q, state_d;
  logic               accept;
  logic               voice_ok_in;

  kind_e              kind_q;
  logic [VoiceW-1:0]  voice_q;
  logic [PrioW-1:0]   prio_q;
  logic               tone_ok_q;
  logic               sample_ok_q;
  logic               off_q;
  logic [EnvW-1:0]    env_q;
  logic               voice_ok_q;

  logic [CW-1:0]      cnt_q;
  logic               cand_vld_q;
  logic [AW-1:0]      cand_idx_q;
  logic [AgeW-1:0]    epoch_q, epoch_d;
  logic               issue;
  logic               scan_end;

  res_t               res_q, res_d;
  logic               out_vld_q;
  res_t               out_q;
  logic               out_load;

  mem_req_t           mem_req;
  voice_entry_t       rd_data;
  sel_t               sel;
  logic               free_hit;

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign voice_ok_in  = {1'b0, item_i.voice} < VW1'(VOICE_COUNT);

  assign issue    = (state_q == S_SCAN) && (cnt_q < CW'(VOICE_COUNT)) && !free_hit;
  assign scan_end = cand_vld_q && (free_hit || (cand_idx_q == AW'(VOICE_COUNT - 1)));
  assign out_load = (state_q == S_DONE) && (!out_vld_q || result_o.ready);

  pva_voice_mem #(
    .VOICE_COUNT(VOICE_COUNT)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  pva_select u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (accept),
    .init_prio_i(item_i.tone_priority),
    .cand_vld_i (cand_vld_q && (state_q == S_SCAN)),
    .cand_i     (rd_data),
    .cand_idx_i (VoiceW'(cand_idx_q)),
    .epoch_i    (epoch_q),
    .sel_o      (sel),
    .free_hit_o (free_hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_e'(item_i.kind))
            KIND_KEY_ON:     state_d = item_i.tone_valid ? S_SCAN : S_DONE;
            KIND_ENV_UPDATE: state_d = voice_ok_in ? S_RD : S_DONE;
            KIND_QUERY:      state_d = voice_ok_in ? S_RD : S_DONE;
            KIND_DIRECT_ON:  state_d = S_START;
            default:         state_d = S_DONE;
          endcase
        end
      end
      S_SCAN:  state_d = scan_end ? S_START : S_SCAN;
      S_START: state_d = S_DONE;
      S_RD:    state_d = S_WR;
      S_WR:    state_d = S_DONE;
      S_DONE:  state_d = out_load ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: memory requests, epoch and result staging
  always_comb begin
    voice_entry_t ent;
    ent     = rd_data;
    mem_req = '0;
    epoch_d = epoch_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          if ((kind_e'(item_i.kind) == KIND_QUERY) && !voice_ok_in) begin
            res_d.status_code = STATUS_BAD_VOICE;
          end
        end
      end
      S_SCAN: begin
        mem_req.rd_en = issue;
        mem_req.addr  = VoiceW'(cnt_q[AW-1:0]);
      end
      S_START: begin
        if (kind_q == KIND_KEY_ON) begin
          if (sel.found) begin
            epoch_d = epoch_q + 1'b1;
            if (sample_ok_q) begin
              mem_req.wr_en = 1'b1;
              mem_req.addr  = sel.idx;
              mem_req.wdata = '{prio: prio_q, age: AgeW'(0) - epoch_d, keyed: 1'b1,
                                is_off: 1'b0, env: '0};
              res_d.accepted     = 1'b1;
              res_d.chosen_voice = sel.idx;
              res_d.was_free     = sel.is_free;
            end
          end
        end else if (voice_ok_q && tone_ok_q && sample_ok_q) begin
          mem_req.wr_en = 1'b1;
          mem_req.addr  = voice_q;
          mem_req.wdata = '{prio: prio_q, age: AgeW'(0) - epoch_q, keyed: 1'b1,
                            is_off: 1'b0, env: '0};
          res_d.accepted     = 1'b1;
          res_d.chosen_voice = voice_q;
        end
      end
      S_RD: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = voice_q;
      end
      S_WR: begin
        if (kind_q == KIND_ENV_UPDATE) begin
          ent.is_off = off_q;
          ent.env    = env_q;
        end else begin
          res_d.accepted     = 1'b1;
          res_d.chosen_voice = voice_q;
          if (rd_data.is_off) begin
            ent.keyed         = 1'b0;
            res_d.status_code = STATUS_OFF;
          end else if (rd_data.keyed) begin
            res_d.status_code = (rd_data.env != '0) ? STATUS_KEYED_SOUND
                                                    : STATUS_KEYED_SILENT;
          end else begin
            res_d.status_code = (rd_data.env != '0) ? STATUS_REL_SOUND : STATUS_OFF;
          end
        end
        mem_req.wr_en = 1'b1;
        mem_req.addr  = voice_q;
        mem_req.wdata = ent;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      epoch_q    <= '0;
      cnt_q      <= '0;
      cand_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      epoch_q    <= epoch_d;
      cand_vld_q <= issue;
      if (accept) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      out_vld_q <= out_load || (out_vld_q && !result_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_e'(item_i.kind);
      voice_q     <= item_i.voice;
      prio_q      <= item_i.tone_priority;
      tone_ok_q   <= item_i.tone_valid;
      sample_ok_q <= item_i.sample_valid;
      off_q       <= item_i.phase_off;
      env_q       <= item_i.envelope_level;
      voice_ok_q  <= voice_ok_in;
    end
    cand_idx_q <= cnt_q[AW-1:0];
    res_q      <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.accepted     = out_q.accepted;
  assign result_o.chosen_voice = out_q.chosen_voice;
  assign result_o.was_free     = out_q.was_free;
  assign result_o.status_code  = out_q.status_code;

  a_mem_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("voice memory read and write in the same cycle");

  a_epoch_only_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_START) |=> $stable(epoch_q))
    else $error("age epoch moved outside key-on start");

  a_idle_no_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(mem_req.rd_en || mem_req.wr_en))
    else $error("voice memory accessed while idle");

  a_free_implies_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.was_free) |-> result_o.accepted)
    else $error("free voice reported on a rejected key-on");

endmodule

### hdl/pva_voice_mem.sv
// Voice table: single-port synchronous memory with registered read data.
// Per-entry valid bits make unwritten voices read as their reset state.
// Depends on pva_pkg.
module pva_voice_mem import pva_pkg::*; #(
  parameter int VOICE_COUNT = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mem_req_t     req_i,
  output voice_entry_t rd_data_o
);

  localparam int AW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  localparam voice_entry_t RST_ENTRY = '{
    prio:   '0,
    age:    AgeW'(VOICE_COUNT),
    keyed:  1'b0,
    is_off: 1'b1,
    env:    '0
  };

  voice_entry_t           mem_q [VOICE_COUNT];
  voice_entry_t           raw_q;
  logic [VOICE_COUNT-1:0] vld_q;
  logic                   rd_vld_q;
  logic [AW-1:0]          addr;

  assign addr = req_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      raw_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? raw_q : RST_ENTRY;

endmodule

### hdl/pva_select.sv
// Key-on candidate tracker: takes one voice entry per cycle during the scan,
// stops at the first free voice, else keeps the best steal candidate.
// Depends on pva_pkg.
module pva_select import pva_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              init_i,
  input  logic [PrioW-1:0]  init_prio_i,
  input  logic              cand_vld_i,
  input  voice_entry_t      cand_i,
  input  logic [VoiceW-1:0] cand_idx_i,
  input  logic [AgeW-1:0]   epoch_i,
  output sel_t              sel_o,
  output logic              free_hit_o
);

  sel_t             sel_q;
  logic [PrioW-1:0] best_prio_q;
  logic [EnvW-1:0]  best_env_q;
  logic [AgeW-1:0]  lead_age_q;
  logic [AgeW-1:0]  age;
  logic             cand_free;
  logic             better;
  logic             take;

  assign age       = cand_i.age + epoch_i;
  assign cand_free = cand_i.is_off && (cand_i.env == '0);
  assign free_hit_o = cand_vld_i && !sel_q.is_free && cand_free;

  assign better = (cand_i.prio < best_prio_q) ||
                  ((cand_i.prio == best_prio_q) &&
                   ((cand_i.env < best_env_q) ||
                    ((cand_i.env == best_env_q) &&
                     ($signed(age) > $signed(lead_age_q)))));

  assign take = cand_vld_i && !sel_q.is_free && !cand_free && better;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else if (init_i) begin
      sel_q <= '0;
    end else if (free_hit_o) begin
      sel_q <= '{found: 1'b1, is_free: 1'b1, idx: cand_idx_i};
    end else if (take) begin
      sel_q <= '{found: 1'b1, is_free: 1'b0, idx: cand_idx_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      best_prio_q <= init_prio_i;
      best_env_q  <= ENV_MAX;
      lead_age_q  <= '0;
    end else if (take) begin
      best_prio_q <= cand_i.prio;
      best_env_q  <= cand_i.env;
      lead_age_q  <= age;
    end
  end

  assign sel_o = sel_q;

endmodule
